// File: src/lrm_pkg.sv
package lrm_pkg;

  localparam int LEAVES = 1024;
  localparam int LOG    = $clog2(LEAVES);
  localparam int NODES  = 2 * LEAVES;
  localparam int NODE_W = LOG + 1;
  localparam int SPAN_W = LOG + 2;
  localparam int LOW_W  = 10;
  localparam int HIGH_W = 11;
  localparam int CMP_W  = (HIGH_W > SPAN_W) ? HIGH_W : SPAN_W;
  localparam int LVL_W  = $clog2(LOG + 1);

  localparam logic [NODE_W-1:0] NODE_MAX = NODE_W'(NODES - 1);
  localparam logic [LVL_W-1:0]  LVL_LAST = LVL_W'(LOG);

  typedef struct packed {
    logic              func;
    logic [LOW_W-1:0]  range_low;
    logic [HIGH_W-1:0] range_high;
  } lrm_item_t;

  typedef struct packed {
    logic              full_we;
    logic [NODE_W-1:0] full_waddr;
    logic              any_we;
    logic [NODE_W-1:0] any_waddr;
    logic              wdata;
    logic [NODE_W-1:0] full_raddr_a;
    logic [NODE_W-1:0] full_raddr_b;
    logic [NODE_W-1:0] any_raddr;
  } lrm_mem_req_t;

  typedef struct packed {
    logic full_a;
    logic full_b;
    logic any;
  } lrm_mem_rsp_t;

endpackage

// File: src/lrm_store.sv
module lrm_store import lrm_pkg::*; (
  input  logic         clk,
  input  lrm_mem_req_t mem_req,
  output lrm_mem_rsp_t mem_rsp
);

  // full: the whole subtree was covered by a mark at this node
  // any: some mark reached this node's range from a boundary path
  logic full_mem [NODES];
  logic any_mem  [NODES];

  always_ff @(posedge clk) begin
    if (mem_req.full_we) begin
      full_mem[mem_req.full_waddr] <= mem_req.wdata;
    end
    if (mem_req.any_we) begin
      any_mem[mem_req.any_waddr] <= mem_req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    mem_rsp.full_a <= full_mem[mem_req.full_raddr_a];
    mem_rsp.full_b <= full_mem[mem_req.full_raddr_b];
    mem_rsp.any    <= any_mem[mem_req.any_raddr];
  end

endmodule

// File: src/lrm_walk.sv
module lrm_walk import lrm_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  lrm_item_t    item,
  output logic         idle,
  output logic         done,
  output logic         result,
  input  logic         res_ready,
  output lrm_mem_req_t mem_req,
  input  lrm_mem_rsp_t mem_rsp
);

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_WALK, S_DRAIN, S_DONE} state_t;

  state_t            state;
  logic [NODE_W-1:0] clr_cnt;
  logic              is_mark;
  logic              side;
  logic [LVL_W-1:0]  lvl;
  logic [SPAN_W-1:0] l;
  logic [SPAN_W-1:0] r;
  logic [NODE_W-1:0] pl;
  logic [NODE_W-1:0] pr;
  logic              rd_live;
  logic              rd_c;
  logic              acc;

  logic [CMP_W-1:0]  lo_ext;
  logic [CMP_W-1:0]  hi_ext;
  logic [CMP_W-1:0]  hi_sat;
  logic              nonempty;
  logic [CMP_W-1:0]  l_sum;
  logic [CMP_W-1:0]  r_sum;
  logic [SPAN_W-1:0] l_init;
  logic [SPAN_W-1:0] r_init;
  logic [SPAN_W-1:0] r_init_dec;

  logic              c_ok;
  logic [SPAN_W-1:0] r_dec;
  logic [SPAN_W-1:0] l_inc;
  logic [NODE_W-1:0] c_addr;
  logic [NODE_W-1:0] p_addr;
  logic              acc_next;

  // saturate the high end, then move both ends to leaf numbering
  always_comb begin
    lo_ext     = CMP_W'(item.range_low);
    hi_ext     = CMP_W'(item.range_high);
    hi_sat     = (hi_ext > CMP_W'(LEAVES)) ? CMP_W'(LEAVES) : hi_ext;
    nonempty   = lo_ext < hi_sat;
    l_sum      = lo_ext + CMP_W'(LEAVES);
    r_sum      = hi_sat + CMP_W'(LEAVES);
    l_init     = l_sum[SPAN_W-1:0];
    r_init     = r_sum[SPAN_W-1:0];
    r_init_dec = r_init - SPAN_W'(1);
  end

  // side 0 serves the left border, side 1 the right border of the level
  always_comb begin
    r_dec  = r - SPAN_W'(1);
    l_inc  = l + SPAN_W'(l[0]);
    c_ok   = (l < r) && (side ? r[0] : l[0]);
    c_addr = side ? r_dec[NODE_W-1:0] : l[NODE_W-1:0];
    p_addr = side ? pr : pl;
  end

  // covered node counts if its full or any flag is set; path nodes by full only
  assign acc_next = acc | (rd_live & ((rd_c & (mem_rsp.full_a | mem_rsp.any)) |
                                      mem_rsp.full_b));

  always_comb begin
    mem_req              = '0;
    mem_req.full_raddr_a = c_addr;
    mem_req.full_raddr_b = p_addr;
    mem_req.any_raddr    = c_addr;
    unique case (state)
      S_CLEAR: begin
        mem_req.full_we    = 1'b1;
        mem_req.full_waddr = clr_cnt;
        mem_req.any_we     = 1'b1;
        mem_req.any_waddr  = clr_cnt;
        mem_req.wdata      = 1'b0;
      end
      S_WALK: begin
        if (is_mark) begin
          mem_req.full_we    = c_ok;
          mem_req.full_waddr = c_addr;
          mem_req.any_we     = 1'b1;
          mem_req.any_waddr  = p_addr;
          mem_req.wdata      = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
      rd_live <= 1'b0;
      acc     <= 1'b0;
      result  <= 1'b0;
    end else begin
      rd_live <= (state == S_WALK) && !is_mark;
      rd_c    <= c_ok;
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + NODE_W'(1);
          if (clr_cnt == NODE_MAX) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            is_mark <= item.func;
            l       <= l_init;
            r       <= r_init;
            pl      <= l_init[NODE_W-1:0];
            pr      <= r_init_dec[NODE_W-1:0];
            lvl     <= '0;
            side    <= 1'b0;
            acc     <= 1'b0;
            result  <= 1'b0;
            state   <= nonempty ? S_WALK : S_DONE;
          end
        end
        S_WALK: begin
          acc  <= acc_next;
          side <= ~side;
          if (side) begin
            l   <= l_inc >> 1;
            r   <= r >> 1;
            pl  <= pl >> 1;
            pr  <= pr >> 1;
            lvl <= lvl + LVL_W'(1);
            if (lvl == LVL_LAST) begin
              state <= S_DRAIN;
            end
          end
        end
        S_DRAIN: begin
          result <= acc_next;
          state  <= S_DONE;
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_CLEAR;
        end
      endcase
    end
  end

  assign idle = (state == S_IDLE);
  assign done = (state == S_DONE);

  a_mark_gives_zero: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && is_mark) |-> !result)
    else $error("mark produced a nonzero result");

  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && !res_ready) |=> (state == S_DONE && $stable(result)))
    else $error("result lost while output slot busy");

  a_clear_complete: assert property (@(posedge clk) disable iff (rst)
    $fell(state == S_CLEAR) |-> $past(clr_cnt) == NODE_MAX)
    else $error("clearing pass ended early");

  a_walk_length: assert property (@(posedge clk) disable iff (rst)
    (state == S_DRAIN) |-> $past(state == S_WALK && side && lvl == LVL_LAST))
    else $error("walk left before the root level");

endmodule

// File: src/lazy_range_mark_any_tree.sv
// Range mark / range any-set tree over LEAVES one-bit positions.
// Input channel (in_valid/in_ready): func 1 marks [range_low, range_high),
// func 0 asks whether any position in that range is marked. range_high
// above LEAVES is taken as LEAVES; an empty or inverted range changes
// nothing and answers 0.
// Output channel (out_valid/out_ready): one any_marked per item, 0 for marks.
// Walk: a nonempty item walks both border paths from leaf to root,
// serving the left border and then the right border at each level,
// then registers its result; an empty range skips the walk.
// One item is in work at a time; the next transfer can be taken from the
// cycle after the result moves to the output register.
// The output register lets the next item be taken and walked while a
// result waits; a finished walk holds until that register is free.
// Reset: synchronous; afterwards both flag memories are cleared one entry
// per cycle, all 2*LEAVES entries, with in_ready low for that time.
module lazy_range_mark_any_tree import lrm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              func,
  input  logic [LOW_W-1:0]  range_low,
  input  logic [HIGH_W-1:0] range_high,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              any_marked
);

  lrm_item_t    item;
  lrm_mem_req_t mem_req;
  lrm_mem_rsp_t mem_rsp;
  logic         walk_idle;
  logic         walk_done;
  logic         walk_result;
  logic         res_ready;
  logic         start;

  assign item.func       = func;
  assign item.range_low  = range_low;
  assign item.range_high = range_high;

  assign in_ready  = walk_idle;
  assign start     = in_valid & walk_idle;
  assign res_ready = !out_valid || out_ready;

  lrm_walk u_walk (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .item      (item),
    .idle      (walk_idle),
    .done      (walk_done),
    .result    (walk_result),
    .res_ready (res_ready),
    .mem_req   (mem_req),
    .mem_rsp   (mem_rsp)
  );

  lrm_store u_store (
    .clk     (clk),
    .mem_req (mem_req),
    .mem_rsp (mem_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (walk_done && res_ready) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (walk_done && res_ready) begin
      any_marked <= walk_result;
    end
  end

endmodule

// File: test/lazy_range_mark_any_tree_tb.sv
typedef enum logic {OP_QUERY = 1'b0, OP_MARK = 1'b1} op_e;

typedef struct {
  bit any;
  int seq;
} awaited_answer_t;

class range_mark_board;
  bit [lrm_pkg::LEAVES-1:0] marked;
  awaited_answer_t awaited[$];
  int errors;
  int marks;
  int queries;
  int hits;
  int seq_in;

  function new();
    marked = '0;
    errors = 0;
    marks = 0;
    queries = 0;
    hits = 0;
    seq_in = 0;
  endfunction

  // flat view of the positions: a mark sets them, a query ORs them
  function bit mark_or_probe(op_e op, int lo, int hi);
    int top;
    bit any;
    top = (hi > lrm_pkg::LEAVES) ? lrm_pkg::LEAVES : hi;
    any = 1'b0;
    for (int p = lo; p < top; p++) begin
      if (op == OP_MARK) marked[p] = 1'b1;
      else any |= marked[p];
    end
    return any;
  endfunction

  function void note_item(op_e op, int lo, int hi);
    awaited_answer_t a;
    a.any = mark_or_probe(op, lo, hi);
    a.seq = seq_in;
    seq_in++;
    awaited.insert(awaited.size(), a);
    if (op == OP_MARK) marks++;
    else begin
      queries++;
      if (a.any) hits++;
    end
  endfunction

  function int pending();
    return awaited.size();
  endfunction

  task report(string msg);
    if (errors < 20) $display("mismatch: %s", msg);
    errors++;
  endtask

  task check_result(bit got);
    awaited_answer_t a;
    if (awaited.size() == 0) begin
      report($sformatf("any_marked=%0b with no item outstanding", got));
    end else begin
      a = awaited.pop_front();
      if (got !== a.any)
        report($sformatf("item %0d: any_marked=%0b, want %0b", a.seq, got, a.any));
    end
  endtask
endclass

module lazy_range_mark_any_tree_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lrm_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int TAIL_CYCLES  = 2 * (LOG + 1) + 8;
  localparam int RANDOM_ITEMS = 1950;
  localparam int HIGH_MAX     = (1 << HIGH_W) - 1;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_ready;
  logic              func;
  logic [LOW_W-1:0]  range_low;
  logic [HIGH_W-1:0] range_high;
  logic              out_valid;
  logic              out_ready;
  logic              any_marked;

  range_mark_board board;
  int cycles = 0;
  int ready_mode = 0;
  int mode_left = 0;
  int phase = 0;

  lazy_range_mark_any_tree DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .func       (func),
    .range_low  (range_low),
    .range_high (range_high),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .any_marked (any_marked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, board.pending());
      $display("FAILED: results differ");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) board.check_result(any_marked);
  end

  // receiver: modes of free flow, random, heavy stall and periodic
  always @(negedge clk) begin
    if (mode_left == 0) begin
      ready_mode = $urandom_range(0, 3);
      mode_left = $urandom_range(20, 300);
    end else begin
      mode_left--;
    end
    case (ready_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      2: out_ready <= ($urandom_range(0, 7) == 0);
      default: out_ready <= (phase % 3 == 0);
    endcase
    phase++;
  end

  task automatic send_item(op_e op, int lo, int hi);
    @(negedge clk);
    in_valid <= 1'b1;
    func <= op;
    range_low <= LOW_W'(lo);
    range_high <= HIGH_W'(hi);
    do @(posedge clk); while (!in_ready);
    board.note_item(op, lo, hi);
  endtask

  task automatic pause_sender(int gap);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (gap) @(negedge clk);
  endtask

  task automatic drain_sender();
    @(negedge clk);
    in_valid <= 1'b0;
    while (board.pending() > 0) @(negedge clk);
  endtask

  // marks stay sparse so queries keep answering both ways
  task automatic send_random_item();
    int r;
    int lo;
    r = $urandom_range(0, 99);
    lo = $urandom_range(0, LEAVES - 1);
    if (r < 8) send_item(OP_MARK, lo, lo + $urandom_range(1, 2));
    else if (r < 9) send_item(OP_MARK, lo, lo + $urandom_range(8, 48));
    else if (r < 12)
      send_item(OP_MARK, $urandom_range(LEAVES - 8, LEAVES - 1),
                $urandom_range(LEAVES, HIGH_MAX));
    else if (r < 16) send_item(OP_MARK, lo, $urandom_range(0, lo));
    else if (r < 55) send_item(OP_QUERY, lo, lo + $urandom_range(1, 6));
    else if (r < 70) send_item(OP_QUERY, lo, lo + $urandom_range(7, 128));
    else if (r < 88) send_item(OP_QUERY, lo, $urandom_range(0, HIGH_MAX));
    else send_item(OP_QUERY, lo, $urandom_range(0, lo));
  endtask

  initial begin
    int sent;
    int burst;
    bit drained;
    board = new();
    rst = 1'b1;
    in_valid = 1'b0;
    func = OP_QUERY;
    range_low = '0;
    range_high = '0;
    out_ready = 1'b0;
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // directed: empty tree, extremes, saturation, empty and inverted ranges
    send_item(OP_QUERY, 0, LEAVES);
    send_item(OP_QUERY, 0, HIGH_MAX);
    send_item(OP_MARK, 5, 5);
    send_item(OP_MARK, 700, 3);
    send_item(OP_QUERY, 0, HIGH_MAX);
    send_item(OP_MARK, LEAVES - 1, HIGH_MAX);
    send_item(OP_QUERY, LEAVES - 1, LEAVES);
    send_item(OP_QUERY, 0, LEAVES - 1);
    send_item(OP_QUERY, LEAVES - 2, LEAVES - 1);
    send_item(OP_MARK, 0, 1);
    send_item(OP_QUERY, 0, 1);
    send_item(OP_QUERY, 1, LEAVES - 1);
    send_item(OP_MARK, LEAVES / 2, LEAVES / 2 + 1);
    send_item(OP_QUERY, LEAVES / 2 - 1, LEAVES / 2);
    send_item(OP_QUERY, LEAVES / 2, LEAVES / 2 + 1);
    send_item(OP_QUERY, LEAVES / 4, 3 * LEAVES / 4);
    // partial cover leaves pending flags below the covering nodes
    send_item(OP_MARK, 300, 310);
    send_item(OP_QUERY, 305, 306);
    send_item(OP_QUERY, 310, LEAVES / 2);
    send_item(OP_QUERY, 0, HIGH_MAX);
    send_item(OP_QUERY, LEAVES - 1, LEAVES - 1);
    send_item(OP_QUERY, LEAVES - 1, 0);
    send_item(OP_QUERY, 1000, LEAVES);
    pause_sender(3);

    sent = 0;
    drained = 1'b0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) == 0) burst = $urandom_range(50, 200);
      else burst = $urandom_range(1, 16);
      for (int i = 0; i < burst && sent < RANDOM_ITEMS; i++) begin
        send_random_item();
        sent++;
      end
      if (!drained && sent >= RANDOM_ITEMS / 2) begin
        drain_sender();
        drained = 1'b1;
      end else begin
        pause_sender($urandom_range(1, 30));
      end
    end

    // whole tree marked at the end, then probes at both edges and the middle
    send_item(OP_MARK, 0, HIGH_MAX);
    send_item(OP_QUERY, 0, 1);
    send_item(OP_QUERY, LEAVES - 1, HIGH_MAX);
    send_item(OP_QUERY, 500, 501);
    @(negedge clk);
    in_valid <= 1'b0;

    while (board.pending() > 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (board.pending() != 0)
      board.report($sformatf("%0d results never arrived", board.pending()));

    $display("run covered %0d marks and %0d queries, %0d queries found a marked position",
             board.marks, board.queries, board.hits);
    $display("sender bursts and gaps, receiver stall modes, one full drain mid-run");
    if (board.errors == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end
endmodule
